// ----- hw/rtl/rsas_pkg.sv -----
// ----------------------------------------------------------------------------
// rsas_pkg
// Shared types and constants for the rotated sorted array search core.
// ----------------------------------------------------------------------------
package rsas_pkg;

  localparam int DATA_W          = 32;
  localparam int FOUND_IDX_W     = 10;
  localparam int ARRAY_DEPTH_DEF = 1024;
  // power of two, so the queue pointers wrap on their own
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] operand;
  } q_item_t;

  // head of the front queue as seen by the back end
  typedef struct packed {
    logic    valid;
    q_item_t item;
  } fq_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PV_CHK,
    ST_PV_RD_NEXT,
    ST_PV_RD_PREV,
    ST_PV_RD_LO,
    ST_PV_STEP,
    ST_BS_CHK,
    ST_BS_CMP,
    ST_DONE
  } back_state_t;

endpackage

// ----- hw/rtl/rsas_if.sv -----
// ----------------------------------------------------------------------------
// rsas_if
// Valid/ready channel interfaces for search items and results.
// ----------------------------------------------------------------------------
interface rsas_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [rsas_pkg::DATA_W-1:0] element_value;
  logic signed [rsas_pkg::DATA_W-1:0] target_value;

  modport source(output valid, cmd, element_value, target_value, input ready);
  modport sink(input valid, cmd, element_value, target_value, output ready);
endinterface

interface rsas_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [rsas_pkg::FOUND_IDX_W-1:0] found_index;

  modport source(output valid, found, found_index, input ready);
  modport sink(input valid, found, found_index, output ready);
endinterface

// ----- hw/rtl/rsas_front.sv -----
// ----------------------------------------------------------------------------
// rsas_front
// Accepts items, classifies them into command and operand, and queues them.
// ----------------------------------------------------------------------------
module rsas_front (
  input  logic                clk,
  input  logic                rst_n,
  rsas_in_if.sink             in_ch,
  output rsas_pkg::fq_t       fq,
  input  logic                pop
);

  localparam int QPW = $clog2(rsas_pkg::QUEUE_DEPTH);

  rsas_pkg::q_item_t q_r [rsas_pkg::QUEUE_DEPTH];
  logic [QPW-1:0]    wr_ptr_r;
  logic [QPW-1:0]    rd_ptr_r;
  logic [QPW:0]      cnt_r;
  logic              push;
  rsas_pkg::q_item_t item;

  assign in_ch.ready = (cnt_r != (QPW+1)'(rsas_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid & in_ch.ready;

  always_comb begin
    item.cmd     = rsas_pkg::cmd_t'(in_ch.cmd);
    item.operand = (item.cmd == rsas_pkg::CMD_SEARCH) ? in_ch.target_value
                                                      : in_ch.element_value;
  end

  assign fq.valid = (cnt_r != '0);
  assign fq.item  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/rsas_back.sv -----
// ----------------------------------------------------------------------------
// rsas_back
// Holds the array store, runs the pivot search and up to two binary searches,
// and drives the registered result channel.
// ----------------------------------------------------------------------------
module rsas_back #(
  parameter int ARRAY_DEPTH = rsas_pkg::ARRAY_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  rsas_pkg::fq_t fq,
  output logic          pop,
  rsas_out_if.source    out_ch
);

  localparam int IW = $clog2(ARRAY_DEPTH);
  localparam int CW = $clog2(ARRAY_DEPTH + 1);
  localparam int DW = rsas_pkg::DATA_W;
  localparam int FW = rsas_pkg::FOUND_IDX_W;

  typedef logic signed [CW:0] sidx_t;

  logic signed [DW-1:0] mem [ARRAY_DEPTH];

  rsas_pkg::back_state_t state_r, state_nxt;
  sidx_t                 lo_r, lo_nxt;
  sidx_t                 hi_r, hi_nxt;
  sidx_t                 mid_r, mid_nxt;
  sidx_t                 pivot_r, pivot_nxt;
  sidx_t                 n_r, n_nxt;
  logic signed [DW-1:0]  vmid_r, vmid_nxt;
  logic signed [DW-1:0]  key_r, key_nxt;
  logic                  phase_r, phase_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  restart_r, restart_nxt;
  logic                  res_found_r, res_found_nxt;
  logic [FW-1:0]         res_idx_r, res_idx_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [FW-1:0]         out_idx_r, out_idx_nxt;
  logic signed [DW-1:0]  rdata_r;

  logic                  we;
  logic [IW-1:0]         waddr;
  logic [IW-1:0]         raddr;
  sidx_t                 pv_diff;
  sidx_t                 pv_mid;
  logic signed [CW+1:0]  bs_sum;
  sidx_t                 bs_mid;
  sidx_t                 mid_p1;
  sidx_t                 mid_m1;
  sidx_t                 cur_n;
  logic                  lo_gt_hi;
  logic                  lo_eq_hi;
  logic                  hit_next;
  logic                  hit_prev;
  logic                  go_right;
  logic                  key_eq;
  logic                  key_gt;
  logic                  out_free;
  logic                  is_load;
  logic                  is_search;

  // shared compares
  assign pv_diff   = hi_r - lo_r;
  assign pv_mid    = lo_r + (pv_diff >>> 1);
  assign bs_sum    = (CW+2)'(lo_r) + (CW+2)'(hi_r);
  assign bs_mid    = bs_sum[CW+1:1];
  assign mid_p1    = mid_r + sidx_t'(1);
  assign mid_m1    = mid_r - sidx_t'(1);
  assign cur_n     = sidx_t'({1'b0, count_r});
  assign lo_gt_hi  = (lo_r > hi_r);
  assign lo_eq_hi  = (lo_r == hi_r);
  assign hit_next  = (mid_r < hi_r) && (vmid_r >= rdata_r);
  assign hit_prev  = (lo_r < mid_r) && (rdata_r >= vmid_r);
  assign go_right  = (rdata_r <= vmid_r);
  assign key_eq    = (key_r == rdata_r);
  assign key_gt    = (key_r > rdata_r);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign is_load   = fq.valid && (fq.item.cmd == rsas_pkg::CMD_LOAD);
  assign is_search = fq.valid && (fq.item.cmd == rsas_pkg::CMD_SEARCH);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.found_index = out_idx_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsas_pkg::ST_IDLE: begin
        if (is_search) begin
          state_nxt = rsas_pkg::ST_PV_CHK;
        end
      end
      rsas_pkg::ST_PV_CHK: begin
        priority if (lo_gt_hi) begin
          state_nxt = rsas_pkg::ST_DONE;
        end else if (lo_eq_hi) begin
          state_nxt = rsas_pkg::ST_BS_CHK;
        end else begin
          state_nxt = rsas_pkg::ST_PV_RD_NEXT;
        end
      end
      rsas_pkg::ST_PV_RD_NEXT: state_nxt = rsas_pkg::ST_PV_RD_PREV;
      rsas_pkg::ST_PV_RD_PREV: begin
        state_nxt = hit_next ? rsas_pkg::ST_BS_CHK : rsas_pkg::ST_PV_RD_LO;
      end
      rsas_pkg::ST_PV_RD_LO: begin
        state_nxt = hit_prev ? rsas_pkg::ST_BS_CHK : rsas_pkg::ST_PV_STEP;
      end
      rsas_pkg::ST_PV_STEP: state_nxt = rsas_pkg::ST_PV_CHK;
      rsas_pkg::ST_BS_CHK: begin
        priority if (lo_gt_hi && phase_r) begin
          state_nxt = rsas_pkg::ST_DONE;
        end else if (!lo_gt_hi) begin
          state_nxt = rsas_pkg::ST_BS_CMP;
        end else begin
          state_nxt = rsas_pkg::ST_BS_CHK;
        end
      end
      rsas_pkg::ST_BS_CMP: begin
        state_nxt = key_eq ? rsas_pkg::ST_DONE : rsas_pkg::ST_BS_CHK;
      end
      rsas_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = rsas_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rsas_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    pivot_nxt     = pivot_r;
    n_nxt         = n_r;
    vmid_nxt      = vmid_r;
    key_nxt       = key_r;
    phase_nxt     = phase_r;
    count_nxt     = count_r;
    restart_nxt   = restart_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    we            = 1'b0;
    waddr         = count_r[IW-1:0];
    raddr         = '0;
    pop           = 1'b0;

    unique case (state_r)
      rsas_pkg::ST_IDLE: begin
        pop = fq.valid;
        if (is_load) begin
          // a load after a search starts a new array; a full store drops it
          if (restart_r) begin
            we          = 1'b1;
            waddr       = '0;
            count_nxt   = CW'(1);
            restart_nxt = 1'b0;
          end else if (count_r < CW'(ARRAY_DEPTH)) begin
            we        = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        if (is_search) begin
          restart_nxt = 1'b1;
          key_nxt     = fq.item.operand;
          n_nxt       = cur_n;
          lo_nxt      = '0;
          hi_nxt      = cur_n - sidx_t'(1);
        end
      end
      rsas_pkg::ST_PV_CHK: begin
        raddr   = pv_mid[IW-1:0];
        mid_nxt = pv_mid;
        priority if (lo_gt_hi) begin
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
        end else if (lo_eq_hi) begin
          pivot_nxt = lo_r;
          hi_nxt    = lo_r;
          lo_nxt    = '0;
          phase_nxt = 1'b0;
        end else begin
          mid_nxt = pv_mid;
        end
      end
      rsas_pkg::ST_PV_RD_NEXT: begin
        raddr    = mid_p1[IW-1:0];
        vmid_nxt = rdata_r;
      end
      rsas_pkg::ST_PV_RD_PREV: begin
        raddr = mid_m1[IW-1:0];
        if (hit_next) begin
          pivot_nxt = mid_r;
          hi_nxt    = mid_r;
          lo_nxt    = '0;
          phase_nxt = 1'b0;
        end
      end
      rsas_pkg::ST_PV_RD_LO: begin
        raddr = lo_r[IW-1:0];
        if (hit_prev) begin
          pivot_nxt = mid_m1;
          hi_nxt    = mid_m1;
          lo_nxt    = '0;
          phase_nxt = 1'b0;
        end
      end
      rsas_pkg::ST_PV_STEP: begin
        if (go_right) begin
          lo_nxt = mid_p1;
        end else begin
          hi_nxt = mid_m1;
        end
      end
      rsas_pkg::ST_BS_CHK: begin
        raddr   = bs_mid[IW-1:0];
        mid_nxt = bs_mid;
        if (lo_gt_hi) begin
          if (phase_r) begin
            res_found_nxt = 1'b0;
            res_idx_nxt   = '0;
          end else begin
            // first part missed: search the part after the pivot
            phase_nxt = 1'b1;
            lo_nxt    = pivot_r + sidx_t'(1);
            hi_nxt    = n_r - sidx_t'(1);
          end
        end
      end
      rsas_pkg::ST_BS_CMP: begin
        priority if (key_eq) begin
          res_found_nxt = 1'b1;
          res_idx_nxt   = FW'(mid_r);
        end else if (key_gt) begin
          lo_nxt = mid_p1;
        end else begin
          hi_nxt = mid_m1;
        end
      end
      rsas_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_idx_nxt   = res_idx_r;
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= fq.item.operand;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsas_pkg::ST_IDLE;
      count_r     <= '0;
      restart_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      restart_r   <= restart_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    pivot_r     <= pivot_nxt;
    n_r         <= n_nxt;
    vmid_r      <= vmid_nxt;
    key_r       <= key_nxt;
    phase_r     <= phase_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
  end

endmodule

// ----- hw/rtl/rotated_sorted_array_search_core.sv -----
// Load item: written to the array store in the back end as it leaves the
// two-entry queue. Search item: a pivot search (four single-port reads over
// five states per step) followed by up to two binary-search passes. The single
// read port of the array store sets the pace; the queue takes new items while
// a search runs. Reset empties the queue, the result register and the element
// count; the store is not cleared.
// ----------------------------------------------------------------------------
// rotated_sorted_array_search_core
// Top level: front queue feeding the search back end.
// ----------------------------------------------------------------------------
module rotated_sorted_array_search_core #(
  parameter int ARRAY_DEPTH = rsas_pkg::ARRAY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rsas_in_if.sink    in_ch,
  rsas_out_if.source out_ch
);

  rsas_pkg::fq_t fq;
  logic          pop;

  rsas_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .fq    (fq),
    .pop   (pop)
  );

  rsas_back #(
    .ARRAY_DEPTH (ARRAY_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .fq     (fq),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ----- hw/rtl/rsas_checker.sv -----
// ----------------------------------------------------------------------------
// rsas_checker
// Port-level checks on the search core, attached by bind.
// ----------------------------------------------------------------------------
module rsas_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             in_cmd,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_found,
  input logic [rsas_pkg::FOUND_IDX_W-1:0] out_found_index
);

  // searches accepted but not yet answered
  logic [2:0] pend_r;
  logic       srch_acc;
  logic       res_acc;

  assign srch_acc = in_valid && in_ready && (in_cmd == rsas_pkg::CMD_SEARCH);
  assign res_acc  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (srch_acc && !res_acc) begin
      pend_r <= pend_r + 1'b1;
    end else if (res_acc && !srch_acc) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found)
      && $stable(out_found_index))
    else $error("stalled result changed");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_index == '0)
    else $error("not-found result with nonzero index");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result without a pending search");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd4)
    else $error("more searches in flight than the core can hold");

endmodule

bind rotated_sorted_array_search_core rsas_checker u_rsas_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .in_cmd          (in_ch.cmd),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_found       (out_ch.found),
  .out_found_index (out_ch.found_index)
);

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotated sorted array search core. Loads rotated
// ascending arrays (plus arrays with duplicates and unsorted noise), searches
// them, and checks every result against a cycle-free predictor of the core.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rsas_pkg::*;

  localparam int ARRAY_DEPTH    = ARRAY_DEPTH_DEF;
  localparam int RANDOM_ITEMS   = 60;
  localparam int DRAIN_EVERY    = 20;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 250;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] element;
    logic signed [DATA_W-1:0] target;
  } req_item_t;

  typedef struct {
    logic                   found;
    logic [FOUND_IDX_W-1:0] index;
  } search_result_t;

  typedef enum {
    SHAPE_WIDE,
    SHAPE_DUP,
    SHAPE_NOISE
  } shape_t;

  logic clk;
  logic rst_n;

  rsas_in_if  in_ch();
  rsas_out_if out_ch();

  rotated_sorted_array_search_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // shadow of the core's state
  logic signed [DATA_W-1:0] shadow_mem [ARRAY_DEPTH];
  int unsigned              shadow_count;
  bit                       restart_pending;

  req_item_t                pending_items[$];
  search_result_t           expected_results[$];
  logic signed [DATA_W-1:0] cur_array[$];
  search_result_t           exp_res;

  bit in_taken;
  bit src_busy;
  int src_gap;
  int sink_gap;
  bit no_gaps;
  bit hold_ready;
  bit random_started;
  int accepted_items;
  int stuck_cycles;
  int mismatch_count;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic longint mem_rd(longint i);
    if (i < 0 || i >= ARRAY_DEPTH) return 0;
    return longint'(shadow_mem[i]);
  endfunction

  // index of the largest element, -1 on an empty range
  function automatic longint find_pivot(longint lo, longint hi);
    longint mid;
    while (lo <= hi) begin
      if (lo == hi) return lo;
      mid = lo + (hi - lo) / 2;
      if (mid < hi && mem_rd(mid) >= mem_rd(mid + 1)) return mid;
      if (lo < mid && mem_rd(mid - 1) >= mem_rd(mid)) return mid - 1;
      if (mem_rd(lo) <= mem_rd(mid)) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic longint bin_find(longint lo, longint hi, longint key);
    longint mid;
    longint v;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      v = mem_rd(mid);
      if (key == v) return mid;
      if (key > v) lo = mid + 1;
      else hi = mid - 1;
    end
    return -1;
  endfunction

  function automatic void apply_item(cmd_t cmd, logic signed [DATA_W-1:0] elem,
                                     logic signed [DATA_W-1:0] tgt);
    longint         pivot;
    longint         hit;
    search_result_t res;
    if (cmd == CMD_LOAD) begin
      // a load after a search begins a new array
      if (restart_pending) begin
        shadow_count = 0;
        restart_pending = 1'b0;
      end
      if (shadow_count < ARRAY_DEPTH) begin
        shadow_mem[shadow_count] = elem;
        shadow_count++;
      end
    end else begin
      restart_pending = 1'b1;
      hit = -1;
      pivot = find_pivot(0, longint'(shadow_count) - 1);
      if (pivot >= 0) begin
        hit = bin_find(0, pivot, longint'(tgt));
        if (hit < 0) hit = bin_find(pivot + 1, longint'(shadow_count) - 1, longint'(tgt));
      end
      res.found = (hit >= 0);
      res.index = (hit >= 0) ? FOUND_IDX_W'(hit) : '0;
      expected_results.push_back(res);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void queue_load(logic signed [DATA_W-1:0] v);
    req_item_t it;
    it.cmd = CMD_LOAD;
    it.element = v;
    it.target = $urandom;
    pending_items.push_back(it);
  endfunction

  function automatic void queue_search(logic signed [DATA_W-1:0] t);
    req_item_t it;
    it.cmd = CMD_SEARCH;
    it.element = $urandom;
    it.target = t;
    pending_items.push_back(it);
  endfunction

  // build an n-element array of the given shape, rotate it and queue the loads
  function automatic void load_array(int n, shape_t shape);
    logic signed [DATA_W-1:0] vals[$];
    longint                   step_max;
    longint                   v;
    int                       rot;
    cur_array.delete();
    step_max = 64'hFFFF_FFFF / (n + 1);
    if (shape == SHAPE_WIDE) v = -64'sd2147483648 + longint'($urandom_range(0, 32'(step_max)));
    else v = longint'($urandom_range(0, 200)) - 100;
    for (int i = 0; i < n; i++) begin
      if (shape == SHAPE_NOISE) begin
        if ($urandom_range(0, 3) == 0) vals.push_back(DATA_W'($urandom_range(0, 7)));
        else vals.push_back($urandom);
      end else begin
        vals.push_back(DATA_W'(v));
        if (shape == SHAPE_WIDE) v += longint'($urandom_range(1, 32'(step_max)));
        else v += longint'($urandom_range(0, 3));
      end
    end
    rot = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      cur_array.push_back(vals[(i + rot) % n]);
      queue_load(vals[(i + rot) % n]);
    end
  endfunction

  // mostly hits, then near misses, random values and the extremes
  function automatic void queue_searches(int m);
    logic signed [DATA_W-1:0] t;
    int                       r;
    repeat (m) begin
      r = $urandom_range(0, 99);
      if (cur_array.size() > 0 && r < 65) begin
        t = cur_array[$urandom_range(0, cur_array.size() - 1)];
      end else if (cur_array.size() > 0 && r < 85) begin
        t = cur_array[$urandom_range(0, cur_array.size() - 1)];
        t = $urandom_range(0, 1) ? t + 1 : t - 1;
      end else if (r < 95) begin
        t = $urandom;
      end else begin
        t = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end
      queue_search(t);
    end
  endfunction

  // wait until every queued item is in and every result is out
  task automatic wait_idle();
    while (pending_items.size() != 0 || src_busy || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_busy = 1'b0;
      src_gap = 0;
    end else begin
      if (src_busy && in_taken) src_busy = 1'b0;
      if (!src_busy) begin
        if (src_gap > 0) begin
          src_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_ch.cmd           <= pending_items[0].cmd;
          in_ch.element_value <= pending_items[0].element;
          in_ch.target_value  <= pending_items[0].target;
          in_ch.valid         <= 1'b1;
          void'(pending_items.pop_front());
          src_busy = 1'b1;
          src_gap = no_gaps ? 0 : pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_gap = 0;
    end else if (hold_ready) begin
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (!no_gaps && $urandom_range(0, 3) == 0) sink_gap = pick_gap();
    end
  end

  // predict on accepted items, check results, watch for a hang
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
      stuck_cycles = 0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        apply_item(cmd_t'(in_ch.cmd), in_ch.element_value, in_ch.target_value);
        accepted_items++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result arrived with none expected");
        end else begin
          exp_res = expected_results.pop_front();
          if (out_ch.found !== exp_res.found)
            report_mismatch($sformatf("found %b, expected %b", out_ch.found, exp_res.found));
          if (out_ch.found_index !== exp_res.index)
            report_mismatch($sformatf("found_index %0d, expected %0d",
                                      out_ch.found_index, exp_res.index));
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
          $display("== FAIL ==");
          $finish;
        end
      end
    end
  end

  // long receiver hold-off early in the random part, so the core backs up
  initial begin
    int start_cnt;
    wait (random_started);
    start_cnt = accepted_items;
    while (accepted_items < start_cnt + 1) @(posedge clk);
    hold_ready = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_ready = 1'b0;
  end

  initial begin
    int     random_items;
    int     next_drain;
    int     chunk;
    int     n;
    int     m;
    int     r;
    shape_t shape;

    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CMD_LOAD;
    in_ch.element_value = '0;
    in_ch.target_value  = '0;
    out_ch.ready        = 1'b0;
    shadow_count        = 0;
    restart_pending     = 1'b1;
    no_gaps             = 1'b0;
    hold_ready          = 1'b0;
    random_started      = 1'b0;
    accepted_items      = 0;
    mismatch_count      = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty array, then extremes in a rotated array
    queue_search(32'sh7FFF_FFFF);
    queue_load(32'sh7FFF_FFFF);
    queue_load(32'sh8000_0000);
    queue_load(-5);
    queue_load(0);
    queue_load(7);
    queue_search(32'sh7FFF_FFFF);
    queue_search(32'sh8000_0000);
    queue_search(7);
    queue_search(3);
    // single element, load after search restarts the array
    queue_load(42);
    queue_search(42);
    queue_search(41);
    // not rotated
    queue_load(1);
    queue_load(2);
    queue_load(3);
    queue_search(3);
    // unsorted
    queue_load(5);
    queue_load(1);
    queue_load(9);
    queue_load(3);
    queue_search(9);
    // all equal
    queue_load(4);
    queue_load(4);
    queue_load(4);
    queue_search(4);
    wait_idle();

    // full store: the two extra loads are dropped
    load_array(ARRAY_DEPTH, SHAPE_WIDE);
    queue_load($urandom);
    queue_load($urandom);
    queue_search(cur_array[ARRAY_DEPTH-1]);
    queue_search(cur_array[0]);
    queue_searches(6);
    wait_idle();

    random_started = 1'b1;
    // a run of searches on the full array backs up while the receiver holds off
    queue_searches(8);
    random_items = 8;
    next_drain = DRAIN_EVERY;
    chunk = 0;
    while (random_items < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(1, 16);
      else if (r < 95) n = $urandom_range(17, 64);
      else n = $urandom_range(65, 100);
      r = $urandom_range(0, 99);
      shape = (r < 70) ? SHAPE_WIDE : (r < 85) ? SHAPE_DUP : SHAPE_NOISE;
      m = $urandom_range(1, 6);
      load_array(n, shape);
      queue_searches(m);
      random_items += n + m;
      if (random_items >= next_drain) begin
        wait_idle();
        next_drain += DRAIN_EVERY;
        chunk++;
        // one stretch runs back to back on both sides
        no_gaps = (chunk == 2);
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- rotated_sorted_array_search_core.f -----
hw/rtl/rsas_pkg.sv
hw/rtl/rsas_if.sv
hw/rtl/rsas_front.sv
hw/rtl/rsas_back.sv
hw/rtl/rotated_sorted_array_search_core.sv
hw/rtl/rsas_checker.sv
bench/testbench.sv
